FILE: sv/aho_corasick_censor_mask_defines.svh
// Assertion macros shared by the checker.
`ifndef AHO_CORASICK_CENSOR_MASK_DEFINES_SVH
`define AHO_CORASICK_CENSOR_MASK_DEFINES_SVH
`define ACM_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define ACM_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: sv/acm_pkg.sv
// Package with constants and types of the censor block.
package acm_pkg;
  localparam int unsigned NodesDef = 1024;
  localparam int unsigned AlphabetDef = 26;
  localparam int unsigned MaxPatternDef = 32;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharUpA = 8'h41;
  localparam logic [7:0] CharStar = 8'h2a;
  localparam logic [2:0] CmdClear = 3'd0;
  localparam logic [2:0] CmdPchar = 3'd1;
  localparam logic [2:0] CmdPend = 3'd2;
  localparam logic [2:0] CmdBuild = 3'd3;
  localparam logic [2:0] CmdText = 3'd4;
  localparam logic [2:0] CmdFlush = 3'd5;
  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindStatus = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StLong = 2'd2;
  localparam logic [1:0] StBad = 2'd3;
endpackage

FILE: sv/acm_if.sv
// Valid/ready channel interfaces for input and result words.
interface acm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] char_code;
  modport source (output valid, command, char_code, input ready);
  modport sink (input valid, command, char_code, output ready);
endinterface

interface acm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic [1:0] status;
  logic       last;
  modport source (output valid, kind, char_out, status, last, input ready);
  modport sink (input valid, kind, char_out, status, last, output ready);
endinterface

FILE: sv/aho_corasick_censor_mask.sv
// Top level of the multi-pattern censor.
// Input words carry a command and a byte over the in channel; result words
// leave over the out channel. Commands: clear, pattern char, pattern end,
// build, text byte, flush.
// A pattern char passes through the insert state; a text byte goes through a trie
// read, a length read and a mask update in turn, as the trie memory has one read port.
// Pattern end answers with one status word, registered in the cycle after it is taken.
// Build walks the trie breadth-first.
// Flush emits one word per cycle from the window while the receiver is ready.
// After reset and after a clear, a clearing pass over every trie entry zeroes the
// trie, link and length memories; no word is taken during it.
// When the receiver stalls, the result register holds and no new word is
// taken until it drains.
module aho_corasick_censor_mask import acm_pkg::*; #(
  parameter int unsigned Nodes = NodesDef,
  parameter int unsigned Alphabet = AlphabetDef,
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  acm_in_if.sink in_i,
  acm_out_if.source out_o
);
  acm_core #(.Nodes(Nodes), .Alphabet(Alphabet), .MaxPattern(MaxPattern)) u_core (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .in_command_i(in_i.command), .in_char_i(in_i.char_code),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .out_kind_o(out_o.kind), .out_char_o(out_o.char_out),
    .out_status_o(out_o.status), .out_last_o(out_o.last)
  );
endmodule

FILE: sv/acm_core.sv
// Sequencer with trie, link and length memories, window and result register.
module acm_core import acm_pkg::*; #(
  parameter int unsigned Nodes = NodesDef,
  parameter int unsigned Alphabet = AlphabetDef,
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] in_command_i,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_char_o,
  output logic [1:0] out_status_o,
  output logic       out_last_o
);
  localparam int unsigned NW = $clog2(Nodes);
  localparam int unsigned AW = $clog2(Alphabet);
  localparam int unsigned GD = Nodes * Alphabet;
  localparam int unsigned GW = $clog2(GD);
  localparam int unsigned LW = $clog2(MaxPattern + 1);
  localparam int unsigned WW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned CW = NW + 1;

  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001, SClr   = 11'b00000000010, SIns  = 11'b00000000100,
    STxt   = 11'b00000001000, SBPop  = 11'b00000010000, SBRd  = 11'b00000100000,
    SBEdge = 11'b00001000000, SBLen  = 11'b00010000000, SFlush = 11'b00100000000,
    SOut   = 11'b01000000000, SBLen2 = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [NW-1:0] gmem [GD];
  logic [NW-1:0] fmem [Nodes];
  logic [LW-1:0] lmem [Nodes];
  logic [NW-1:0] qmem [Nodes];
  logic [NW-1:0] g_rd, f_rd, q_rd;
  logic [LW-1:0] l_rd;
  logic [GW-1:0] g_ra, g_wa;
  logic [NW-1:0] f_ra, f_wa, l_ra, l_wa, q_ra, q_wa, g_wd, f_wd;
  logic [LW-1:0] l_wd;
  logic          g_we, f_we, l_we, q_we;

  always_ff @(posedge clk_i) begin
    if (g_we) gmem[g_wa] <= g_wd;
    if (f_we) fmem[f_wa] <= f_wd;
    if (l_we) lmem[l_wa] <= l_wd;
    if (q_we) qmem[q_wa] <= g_wd;
    g_rd <= gmem[g_ra];
    f_rd <= fmem[f_ra];
    l_rd <= lmem[l_ra];
    q_rd <= qmem[q_ra];
  end

  logic [NW-1:0] gv, fv;
  logic [LW-1:0] lv;
  assign gv = g_rd;
  assign fv = f_rd;
  assign lv = l_rd;

  logic [7:0] ch_q;
  logic [AW-1:0] idx_q;
  logic [CW-1:0] ncnt_q, ncnt_d;
  logic [NW-1:0] ins_q, ins_d, tnode_q, tnode_d;
  logic [LW-1:0] plen_q, plen_d;
  logic [1:0]    perr_q, perr_d;
  logic [7:0]    wb_q [MaxPattern];
  logic [MaxPattern-1:0] wm_q, wm_d;
  logic [LW-1:0] wf_q, wf_d;
  logic [LW-1:0] fl_q, fl_d;
  logic [CW-1:0] head_q, head_d, tail_q, tail_d;
  logic [NW-1:0] u_q, u_d, fu_q, fu_d;
  logic [AW-1:0] bi_q, bi_d;
  logic [NW-1:0] v_q, v_d;
  logic [LW-1:0] lu_q, lu_d;
  logic          ov_q, ov_d, olast_q, olast_d, shift_en, wr_en;
  logic [1:0]    okind_q, okind_d, ost_q, ost_d;
  logic [7:0]    och_q, och_d;
  logic [GW-1:0] clr_q, clr_d;
  logic          acc;

  assign in_ready_o = (state_q == SIdle) && !ov_q;
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_kind_o = okind_q;
  assign out_char_o = och_q;
  assign out_status_o = ost_q;
  assign out_last_o = olast_q;

  function automatic logic [AW:0] lidx(input logic [7:0] c, input logic up);
    logic [8:0] d;
    d = 9'(c) - 9'(CharLowA);
    if (d < 9'(Alphabet) && d < 9'd26) return (AW+1)'(d);
    d = 9'(c) - 9'(CharUpA);
    if (up && d < 9'(Alphabet) && d < 9'd26) return (AW+1)'(d);
    return (AW+1)'(Alphabet);
  endfunction

  logic [AW:0] li;
  assign li = lidx(in_char_i, in_command_i == CmdText);

  always_comb begin
    state_d = state_q; ncnt_d = ncnt_q; ins_d = ins_q; tnode_d = tnode_q;
    plen_d = plen_q; perr_d = perr_q; wm_d = wm_q; wf_d = wf_q; fl_d = fl_q;
    head_d = head_q; tail_d = tail_q; u_d = u_q; fu_d = fu_q; bi_d = bi_q;
    v_d = v_q; lu_d = lu_q; clr_d = clr_q;
    ov_d = ov_q && !out_ready_i; okind_d = okind_q; och_d = och_q; ost_d = ost_q;
    olast_d = olast_q; shift_en = 1'b0; wr_en = 1'b0;
    g_ra = GW'(ins_q) * GW'(Alphabet); f_ra = '0; l_ra = '0; q_ra = '0;
    g_we = 1'b0; g_wa = '0; g_wd = '0; f_we = 1'b0; f_wa = '0; f_wd = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0; q_we = 1'b0; q_wa = '0;
    case (state_q)
      SIdle: if (acc) begin
        case (in_command_i)
          CmdClear: begin
            state_d = SClr; clr_d = '0; ncnt_d = '0; ins_d = '0; tnode_d = '0;
            plen_d = '0; perr_d = '0; wm_d = '0; wf_d = '0;
          end
          CmdPchar: if (perr_q == StOk) begin
            if (li >= (AW+1)'(Alphabet)) perr_d = StBad;
            else if (plen_q >= LW'(MaxPattern)) perr_d = StLong;
            else begin
              g_ra = GW'(ins_q) * GW'(Alphabet) + GW'(li); state_d = SIns;
            end
          end
          CmdPend: begin
            if (perr_q == StOk && plen_q != '0) begin
              l_we = 1'b1; l_wa = ins_q; l_wd = plen_q;
            end
            ov_d = 1'b1; okind_d = KindStatus; och_d = '0; ost_d = perr_q;
            olast_d = 1'b0; state_d = SOut;
            ins_d = '0; plen_d = '0; perr_d = StOk;
          end
          CmdBuild: begin
            q_we = 1'b1; q_wa = '0; head_d = '0; tail_d = CW'(1); fl_d = '0;
            state_d = SBPop;
          end
          CmdText: begin
            if (li < (AW+1)'(Alphabet)) begin
              g_ra = GW'(tnode_q) * GW'(Alphabet) + GW'(li); state_d = STxt;
            end else begin
              l_ra = '0; tnode_d = '0; state_d = STxt;
            end
            if (wf_q >= LW'(MaxPattern)) begin
              ov_d = 1'b1; okind_d = KindByte; och_d = wm_q[0] ? CharStar : wb_q[0];
              ost_d = StOk; olast_d = 1'b0; shift_en = 1'b1;
              wf_d = LW'(MaxPattern - 1); wm_d = wm_q >> 1;
            end
          end
          CmdFlush: begin
            tnode_d = '0; fl_d = '0;
            if (wf_q == '0) begin
              ov_d = 1'b1; okind_d = KindEmpty; och_d = '0; ost_d = StOk;
              olast_d = 1'b1; state_d = SOut;
            end else state_d = SFlush;
          end
          default: ;
        endcase
      end
      SClr: begin
        g_we = 1'b1; g_wa = clr_q;
        if (clr_q < GW'(Nodes)) begin
          f_we = 1'b1; f_wa = NW'(clr_q); l_we = 1'b1; l_wa = NW'(clr_q);
        end
        if (clr_q == GW'(GD - 1)) state_d = SIdle;
        else clr_d = clr_q + GW'(1);
      end
      SIns: begin
        if (gv == '0) begin
          if (ncnt_q + CW'(1) >= CW'(Nodes)) begin
            perr_d = StFull;
          end else begin
            ncnt_d = ncnt_q + CW'(1);
            g_we = 1'b1; g_wa = GW'(ins_q) * GW'(Alphabet) + GW'(idx_q);
            g_wd = NW'(ncnt_q + CW'(1)); ins_d = NW'(ncnt_q + CW'(1));
            plen_d = plen_q + LW'(1);
          end
        end else begin
          ins_d = gv; plen_d = plen_q + LW'(1);
        end
        state_d = SIdle;
      end
      STxt: begin
        state_d = SBLen2;
        tnode_d = (lidx(ch_q, 1'b1) < (AW+1)'(Alphabet)) ? gv : '0;
        l_ra = (lidx(ch_q, 1'b1) < (AW+1)'(Alphabet)) ? gv : '0;
        wr_en = 1'b1; wf_d = wf_q + LW'(1);
      end
      SBLen2: begin
        for (int k = 0; k < MaxPattern; k++) begin
          if (LW'(k) < wf_q && (wf_q - LW'(k)) <= lv) wm_d[k] = 1'b1;
        end
        state_d = ov_q ? SOut : SIdle;
      end
      SFlush: if (!ov_q || out_ready_i) begin
        ov_d = 1'b1; okind_d = KindByte; ost_d = StOk;
        och_d = wm_q[WW'(fl_q)] ? CharStar : wb_q[WW'(fl_q)];
        olast_d = (fl_q + LW'(1) == wf_q); fl_d = fl_q + LW'(1);
        if (fl_q + LW'(1) == wf_q) begin
          wf_d = '0; wm_d = '0; state_d = SOut;
        end
      end
      SOut: if (!ov_q || out_ready_i) state_d = SIdle;
      SBPop: begin
        if (head_q < tail_q) begin
          q_ra = NW'(head_q); head_d = head_q + CW'(1); state_d = SBRd;
        end else state_d = SIdle;
      end
      SBRd: begin
        u_d = q_rd; f_ra = q_rd; l_ra = q_rd; bi_d = '0; state_d = SBLen;
      end
      SBLen: begin
        fu_d = fv; lu_d = lv; l_ra = fv;
        g_ra = GW'(u_q) * GW'(Alphabet);
        f_ra = '0; state_d = SBEdge; v_d = '0;
      end
      SBEdge: begin
        // Two passes per edge: read own entry, then the parent failure entry.
        if (fl_q == '0) begin
          v_d = gv; fl_d = LW'(1);
          g_ra = GW'(fu_q) * GW'(Alphabet) + GW'(bi_q);
          if (bi_q == '0 && lv > lu_q) begin
            l_we = 1'b1; l_wa = u_q; l_wd = lv;
          end
        end else begin
          fl_d = '0;
          if (v_q != '0) begin
            if (tail_q < CW'(Nodes)) begin
              q_we = 1'b1; q_wa = NW'(tail_q); tail_d = tail_q + CW'(1);
              g_wd = v_q;
            end
            f_we = 1'b1; f_wa = v_q; f_wd = (u_q == '0) ? '0 : gv;
          end else begin
            g_we = 1'b1; g_wa = GW'(u_q) * GW'(Alphabet) + GW'(bi_q);
            g_wd = (u_q == '0) ? '0 : gv;
          end
          if (bi_q == AW'(Alphabet - 1)) state_d = SBPop;
          else begin
            bi_d = bi_q + AW'(1);
            g_ra = GW'(u_q) * GW'(Alphabet) + GW'(bi_q + AW'(1));
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; ncnt_q <= '0; ins_q <= '0; tnode_q <= '0; plen_q <= '0;
      perr_q <= '0; wm_q <= '0; wf_q <= '0; fl_q <= '0; head_q <= '0;
      tail_q <= '0; ov_q <= 1'b0; clr_q <= '0;
    end else begin
      state_q <= state_d; ncnt_q <= ncnt_d; ins_q <= ins_d; tnode_q <= tnode_d;
      plen_q <= plen_d; perr_q <= perr_d; wm_q <= wm_d; wf_q <= wf_d;
      fl_q <= fl_d; head_q <= head_d; tail_q <= tail_d; ov_q <= ov_d; clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d; fu_q <= fu_d; bi_q <= bi_d; v_q <= v_d; lu_q <= lu_d;
    okind_q <= okind_d; och_q <= och_d; ost_q <= ost_d; olast_q <= olast_d;
    if (acc) begin
      ch_q <= in_char_i; idx_q <= AW'(li);
    end
    if (shift_en) for (int k = 0; k < MaxPattern - 1; k++) wb_q[k] <= wb_q[k+1];
    if (wr_en) wb_q[WW'(wf_q)] <= ch_q;
  end
endmodule

FILE: sv/acm_checker.sv
// Port checker for the censor block and its bind.
`include "aho_corasick_censor_mask_defines.svh"
module acm_checker import acm_pkg::*; (
  input logic clk_i, input logic rst_ni,
  input logic ir, input logic ov, input logic ordy,
  input logic [1:0] kind, input logic last, input logic [1:0] st
);
  `ACM_ASSERT_NEXT(a_hold, clk_i, rst_ni, ov && !ordy, $stable(kind) && $stable(last) && $stable(st))
  `ACM_ASSERT_NEXT(a_stay, clk_i, rst_ni, ov && !ordy, ov)
  `ACM_ASSERT_IMPL(a_nort, clk_i, rst_ni, ov, !ir)
  `ACM_ASSERT_IMPL(a_empty, clk_i, rst_ni, ov && kind == KindEmpty, last && st == StOk)
endmodule

bind aho_corasick_censor_mask acm_checker u_chk (
  .clk_i, .rst_ni, .ir(in_i.ready), .ov(out_o.valid),
  .ordy(out_o.ready), .kind(out_o.kind), .last(out_o.last), .st(out_o.status)
);

FILE: test/aho_corasick_censor_mask_tb.sv
// Testbench for the multi-pattern censor: directed and random words checked against a model.
`timescale 1ns / 100ps

module aho_corasick_censor_mask_tb;
  import acm_pkg::*;

  localparam int unsigned NodeMax = NodesDef;
  localparam int unsigned Alpha = AlphabetDef;
  localparam int unsigned Win = MaxPatternDef;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [1:0] status;
    logic       last;
  } censor_word_t;

  class censor_scoreboard;
    logic [9:0] trie_next[NodeMax*Alpha];
    logic [9:0] fail_node[NodeMax];
    logic [5:0] hit_len[NodeMax];
    logic [9:0] walk_queue[NodeMax];
    int unsigned nodes_used, ins_node, pat_len, pat_err, scan_node, fill;
    logic [7:0] win_byte[Win];
    bit win_star[Win];
    censor_word_t pending[$];
    int errors, checked;

    function void clear_all();
      foreach (trie_next[i]) trie_next[i] = '0;
      foreach (fail_node[i]) fail_node[i] = '0;
      foreach (hit_len[i]) hit_len[i] = '0;
      foreach (win_star[i]) win_star[i] = 0;
      nodes_used = 0; ins_node = 0; pat_len = 0; pat_err = 0;
      scan_node = 0; fill = 0;
    endfunction

    function void push(logic [1:0] k, logic [7:0] c, logic [1:0] s, logic l);
      censor_word_t w;
      w.kind = k; w.char_out = c; w.status = s; w.last = l;
      pending.push_back(w);
    endfunction

    function void build_links();
      int unsigned head, tail, u, fu, v, via;
      head = 0; tail = 0;
      walk_queue[tail++] = '0;
      while (head < tail) begin
        u = walk_queue[head++] % NodeMax;
        fu = fail_node[u] % NodeMax;
        for (int i = 0; i < Alpha; i++) begin
          v = trie_next[u*Alpha+i] % NodeMax;
          via = (u == 0) ? 0 : trie_next[fu*Alpha+i];
          if (v != 0) begin
            if (tail < NodeMax) walk_queue[tail++] = 10'(v);
            fail_node[v] = 10'(via);
          end else begin
            trie_next[u*Alpha+i] = 10'(via);
          end
        end
        if (hit_len[fu] > hit_len[u]) hit_len[u] = hit_len[fu];
      end
    endfunction

    function void note_input(logic [2:0] cmd, logic [7:0] c);
      int unsigned idx, e, len;
      case (cmd)
        CmdClear: clear_all();
        CmdPchar: begin
          if (pat_err == 0) begin
            idx = (c >= CharLowA && c < CharLowA + 26) ? c - CharLowA : Alpha;
            if (idx >= Alpha) pat_err = StBad;
            else if (pat_len >= Win) pat_err = StLong;
            else begin
              e = (ins_node % NodeMax) * Alpha + idx;
              if (trie_next[e] == 0 && nodes_used + 1 >= NodeMax) pat_err = StFull;
              else begin
                if (trie_next[e] == 0) begin
                  nodes_used++;
                  trie_next[e] = 10'(nodes_used);
                end
                ins_node = trie_next[e] % NodeMax;
                pat_len++;
              end
            end
          end
        end
        CmdPend: begin
          if (pat_err == 0 && pat_len != 0) hit_len[ins_node % NodeMax] = 6'(pat_len);
          push(KindStatus, 8'd0, 2'(pat_err), 1'b0);
          ins_node = 0; pat_len = 0; pat_err = 0;
        end
        CmdBuild: build_links();
        CmdText: begin
          if (c >= CharLowA && c < CharLowA + 26) idx = c - CharLowA;
          else if (c >= CharUpA && c < CharUpA + 26) idx = c - CharUpA;
          else idx = Alpha;
          scan_node = (idx < Alpha) ? trie_next[(scan_node % NodeMax)*Alpha+idx] % NodeMax : 0;
          if (fill >= Win) begin
            push(KindByte, win_star[0] ? CharStar : win_byte[0], StOk, 1'b0);
            for (int k = 0; k < Win - 1; k++) begin
              win_byte[k] = win_byte[k+1];
              win_star[k] = win_star[k+1];
            end
            fill = Win - 1;
          end
          win_byte[fill] = c; win_star[fill] = 0; fill++;
          len = hit_len[scan_node];
          if (len > fill) len = fill;
          for (int k = 0; k < len; k++) win_star[fill-1-k] = 1;
        end
        CmdFlush: begin
          if (fill == 0) push(KindEmpty, 8'd0, StOk, 1'b1);
          else for (int k = 0; k < fill; k++)
            push(KindByte, win_star[k] ? CharStar : win_byte[k], StOk, k + 1 == fill);
          fill = 0;
          foreach (win_star[i]) win_star[i] = 0;
          scan_node = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(censor_word_t got);
      censor_word_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word kind=%0d char=%0d status=%0d last=%0d",
                 $time, got.kind, got.char_out, got.status, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected kind=%0d char=%0d status=%0d last=%0d",
                 $time, want.kind, want.char_out, want.status, want.last);
        $display("%0t:          actual   kind=%0d char=%0d status=%0d last=%0d",
                 $time, got.kind, got.char_out, got.status, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  acm_in_if in_ch();
  acm_out_if out_ch();
  censor_scoreboard sb = new();
  int hold_cycles = 0;
  bit stall_wide = 0;
  int words_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aho_corasick_censor_mask u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  initial begin
    #20ms;
    $display("FAIL aho_corasick_censor_mask");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.kind, out_ch.char_out, out_ch.status, out_ch.last});
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < hold_cycles; i++) @(negedge clk_i);
        hold_cycles = 0;
      end
      gap = stall_wide ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [7:0] c);
    int gap;
    gap = stall_wide ? $urandom_range(0, 12) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.char_code <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_input(cmd, c);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send_pattern(string s);
    for (int i = 0; i < s.len(); i++) send_word(CmdPchar, s[i]);
    send_word(CmdPend, 8'd0);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(CmdText, s[i]);
  endtask

  function automatic logic [7:0] rand_letter(bit upper);
    return 8'((upper ? CharUpA : CharLowA) + $urandom_range(0, 3));
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CmdClear;
    in_ch.char_code = 8'd0;
    sb.clear_all();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(CmdFlush, 8'd0);
    send_pattern("ab");
    send_pattern("b");
    send_pattern("aB");
    send_pattern("z");
    send_word(CmdPend, 8'd0);
    send_pattern("abcdefghijklmnopqrstuvwxyzabcdefg");
    send_word(CmdBuild, 8'd0);
    send_word(3'd6, 8'hff);
    send_word(3'd7, 8'h00);
    send_text("xAbz{");
    send_word(CmdText, 8'hff);
    send_word(CmdText, 8'h00);
    send_word(CmdFlush, 8'd0);
    drain();

    stall_wide = 1;
    for (int round = 0; round < 6; round++) begin
      int n;
      send_word(CmdClear, 8'd0);
      for (int p = 0; p < 3; p++) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_word(CmdPchar, rand_letter(0));
        if ($urandom_range(0, 5) == 0) send_word(CmdPchar, 8'($urandom_range(0, 255)));
        send_word(CmdPend, 8'd0);
      end
      send_word(CmdBuild, 8'd0);
      if (round == 2) hold_cycles = 300;
      n = (round == 2) ? 45 : $urandom_range(3, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) send_word(CmdText, 8'($urandom_range(0, 255)));
        else send_word(CmdText, rand_letter(1'($urandom_range(0, 1))));
      end
      send_word(CmdFlush, 8'd0);
      if (round == 3) drain();
    end
    drain();

    stall_wide = 0;
    send_word(CmdClear, 8'd0);
    send_pattern("aa");
    send_word(CmdBuild, 8'd0);
    send_text("aaaa");
    send_word(CmdFlush, 8'd0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Covered %0d input words and %0d result words: errors, overflow, stalls.",
               words_sent, sb.checked);
      $display("PASS aho_corasick_censor_mask");
    end else begin
      $display("Covered %0d input words, %0d errors, %0d words left.",
               words_sent, sb.errors, sb.pending.size());
      $display("FAIL aho_corasick_censor_mask");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/acm_pkg.sv
sv/acm_if.sv
sv/acm_core.sv
sv/aho_corasick_censor_mask.sv
sv/acm_checker.sv
test/aho_corasick_censor_mask_tb.sv
